/* design/alc_pkg.sv */
// Shared types and constants for the average-linkage clusterer.
// Holds the transfer payload structs, the merge candidate struct and register codes.
// No dependencies.
package alc_pkg;

	localparam int POINT_W = 6;
	localparam int LABEL_W = 7;
	localparam int SCORE_W = 32;
	localparam int THR_W   = 31;
	localparam int SUM_W   = 48;
	localparam int ID_W    = 7;
	localparam int SIZE_W  = 7;
	localparam int Q_W     = 2 * SIZE_W;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// configuration register indexes
	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_MISSING   = 2'd1;
	localparam logic [1:0] CFG_MIN_CLUST = 2'd2;
	localparam logic [1:0] CFG_PCOUNT    = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [POINT_W-1:0] first_point;
		logic [POINT_W-1:0] second_point;
		logic [SCORE_W-1:0] score;
	} in_item_t;

	typedef struct packed {
		logic [POINT_W-1:0] point_index;
		logic [LABEL_W-1:0] cluster_label;
		logic               last;
	} out_item_t;

	// one cluster slot as stored in the slot memory
	typedef struct packed {
		logic              active;
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
	} slot_t;

	// a merge candidate: summed distance, size product, ordered ids
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [Q_W-1:0]   q;
		logic [ID_W-1:0]  lo;
		logic [ID_W-1:0]  hi;
	} cand_t;

endpackage

/* design/alc_cmp.sv */
// Exact rational compare of a merge candidate against the threshold and the best so far.
// One registered multiply stage, then the compare. Depends on alc_pkg.
module alc_cmp (
	input  logic                      clk,
	input  logic                      en,
	input  alc_pkg::cand_t            cand,
	input  alc_pkg::cand_t            best,
	input  logic [alc_pkg::THR_W-1:0] threshold,
	output logic                      qualify,
	output logic                      better
);
	import alc_pkg::*;

	localparam int PROD_W = SUM_W + Q_W + 1;
	localparam int THQ_W  = THR_W + Q_W;

	logic [THQ_W-1:0]         thq_s2;
	logic signed [PROD_W-1:0] lhs_s2;
	logic signed [PROD_W-1:0] rhs_s2;

	// cross products: cand.sum * best.q against best.sum * cand.q
	always_ff @(posedge clk) begin
		if (en) begin
			thq_s2 <= {{Q_W{1'b0}}, threshold} * {{THR_W{1'b0}}, cand.q};
			lhs_s2 <= $signed({{(Q_W+1){cand.sum[SUM_W-1]}}, cand.sum})
				* $signed({{(SUM_W+1){1'b0}}, best.q});
			rhs_s2 <= $signed({{(Q_W+1){best.sum[SUM_W-1]}}, best.sum})
				* $signed({{(SUM_W+1){1'b0}}, cand.q});
		end
	end

	// average at most threshold, then ordering with id tie break
	always_comb begin
		qualify = $signed({cand.sum[SUM_W-1], cand.sum})
			<= $signed({{(SUM_W+1-THQ_W){1'b0}}, thq_s2});
		better = (lhs_s2 < rhs_s2) || ((lhs_s2 == rhs_s2) &&
			((cand.lo < best.lo) || ((cand.lo == best.lo) && (cand.hi < best.hi))));
	end

endmodule

/* design/average_linkage_clusterer.sv */
// Average-linkage clusterer. A load item is written as it is taken; a run item sweeps the pair
// memory (a read and a write per entry over the whole pair address space, MAX_POINTS^2 entries
// for a power of two), then each merge scans all pairs (read, multiply and compare in turn, set
// by the single-port pair memory and the compare multiplier) and rewrites one row. Labels leave
// one at a time. After reset a clearing pass over the same pair space clears the loaded marks
// before the first item is taken; control and configuration registers reset to their defaults.
module average_linkage_clusterer #(
	parameter int MAX_POINTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  alc_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output alc_pkg::out_item_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [alc_pkg::SCORE_W-1:0] cfg_data
);
	import alc_pkg::*;

	localparam int PW    = $clog2(MAX_POINTS);
	localparam int CW    = PW + 1;
	localparam int AW    = 2 * PW;
	localparam int PAIRS = 2 ** AW;
	localparam int RANKS = 2 ** ID_W;

	localparam logic [4:0] ST_CLEAR     = 5'd0;
	localparam logic [4:0] ST_IDLE      = 5'd1;
	localparam logic [4:0] ST_SWEEP_RD  = 5'd2;
	localparam logic [4:0] ST_SWEEP_WR  = 5'd3;
	localparam logic [4:0] ST_SLOT_INIT = 5'd4;
	localparam logic [4:0] ST_SCAN      = 5'd5;
	localparam logic [4:0] ST_ROW       = 5'd6;
	localparam logic [4:0] ST_ROW_D     = 5'd7;
	localparam logic [4:0] ST_PAIR      = 5'd8;
	localparam logic [4:0] ST_PAIR_D    = 5'd9;
	localparam logic [4:0] ST_MUL       = 5'd10;
	localparam logic [4:0] ST_CMP       = 5'd11;
	localparam logic [4:0] ST_MERGE     = 5'd12;
	localparam logic [4:0] ST_MRG_RD1   = 5'd13;
	localparam logic [4:0] ST_MRG_RD2   = 5'd14;
	localparam logic [4:0] ST_MRG_WR    = 5'd15;
	localparam logic [4:0] ST_SLOT_GONE = 5'd16;
	localparam logic [4:0] ST_SLOT_KEEP = 5'd17;
	localparam logic [4:0] ST_RL_RD     = 5'd18;
	localparam logic [4:0] ST_RL_WR     = 5'd19;
	localparam logic [4:0] ST_RANK_CLR  = 5'd20;
	localparam logic [4:0] ST_MARK_RD   = 5'd21;
	localparam logic [4:0] ST_MARK_WR   = 5'd22;
	localparam logic [4:0] ST_RANK_RD   = 5'd23;
	localparam logic [4:0] ST_RANK_WR   = 5'd24;
	localparam logic [4:0] ST_EMIT_RD   = 5'd25;
	localparam logic [4:0] ST_EMIT_SLOT = 5'd26;
	localparam logic [4:0] ST_EMIT_RANK = 5'd27;
	localparam logic [4:0] ST_EMIT_OUT  = 5'd28;

	function automatic logic [AW-1:0] pidx(input logic [PW-1:0] x, input logic [PW-1:0] y);
		pidx = (x < y) ? {x, y} : {y, x};
	endfunction

	// configuration registers
	logic [THR_W-1:0]   thr_q;
	logic [SCORE_W-1:0] miss_q;
	logic [6:0]         minc_q;
	logic [6:0]         pcount_q;

	// control state
	logic [4:0]        state_q;
	logic [AW-1:0]     sw_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     active_q;
	logic [ID_W-1:0]   next_id_q;
	logic [CW-1:0]     a_q;
	logic [CW-1:0]     b_q;
	logic [CW-1:0]     k_q;
	logic [ID_W-1:0]   r_q;
	logic [LABEL_W-1:0] cnt_q;
	logic              found_q;
	logic              kact_q;
	logic              out_valid_q;

	// payload registers
	slot_t            aslot_q;
	cand_t            cand_s1;
	logic [PW-1:0]    ckeep_s1;
	logic [PW-1:0]    cgone_s1;
	logic [SIZE_W-1:0] csize_s1;
	cand_t            best_q;
	logic [PW-1:0]    keep_q;
	logic [PW-1:0]    gone_q;
	logic [SIZE_W-1:0] bsize_q;
	logic [SUM_W-1:0] sum1_q;
	out_item_t        out_q;

	// memories: bit SUM_W of a pair word is the loaded mark
	logic [SUM_W:0]     pair_mem [PAIRS];
	slot_t              slot_mem [MAX_POINTS];
	logic [PW-1:0]      pslot_mem [MAX_POINTS];
	logic [LABEL_W:0]   rank_mem [RANKS];

	logic [SUM_W:0]   pair_rd_q;
	slot_t            slot_rd_q;
	logic [PW-1:0]    pslot_rd_q;
	logic [LABEL_W:0] rank_rd_q;

	logic [AW-1:0]    pair_raddr, pair_waddr;
	logic             pair_we;
	logic [SUM_W:0]   pair_wdata;
	logic [PW-1:0]    slot_raddr, slot_waddr;
	logic             slot_we;
	slot_t            slot_wdata;
	logic [PW-1:0]    pslot_raddr, pslot_waddr;
	logic             pslot_we;
	logic [PW-1:0]    pslot_wdata;
	logic [ID_W-1:0]  rank_raddr, rank_waddr;
	logic             rank_we;
	logic [LABEL_W:0] rank_wdata;

	logic             in_fire;
	logic             load_ok;
	logic [PW-1:0]    sw_i, sw_j;
	logic             sw_inuse;
	logic [SUM_W-1:0] miss48;
	logic [SUM_W:0]   msum;
	logic [SUM_W-1:0] msat;
	logic             qualify, better;
	logic             out_free;
	logic [LABEL_W-1:0] rank_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign load_ok = !in_data.kind && (in_data.first_point != in_data.second_point)
		&& ({1'b0, in_data.first_point} < 7'(MAX_POINTS))
		&& ({1'b0, in_data.second_point} < 7'(MAX_POINTS));
	assign sw_i     = sw_q[AW-1:PW];
	assign sw_j     = sw_q[PW-1:0];
	assign sw_inuse = (sw_i < sw_j) && ({1'b0, sw_j} < n_q);
	assign miss48   = {{(SUM_W-SCORE_W){miss_q[SCORE_W-1]}}, miss_q};
	assign msum     = {sum1_q[SUM_W-1], sum1_q} + {pair_rd_q[SUM_W-1], pair_rd_q[SUM_W-1:0]};
	assign msat     = (msum[SUM_W] != msum[SUM_W-1])
		? (msum[SUM_W] ? SUM_MIN : SUM_MAX) : msum[SUM_W-1:0];
	assign rank_next = cnt_q + LABEL_W'(rank_rd_q[LABEL_W]);

	alc_cmp u_cmp (
		.clk       (clk),
		.en        (state_q == ST_MUL),
		.cand      (cand_s1),
		.best      (best_q),
		.threshold (thr_q),
		.qualify   (qualify),
		.better    (better)
	);

	// memory ports
	always_ff @(posedge clk) begin
		if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
		pair_rd_q <= pair_mem[pair_raddr];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		slot_rd_q <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (pslot_we) pslot_mem[pslot_waddr] <= pslot_wdata;
		pslot_rd_q <= pslot_mem[pslot_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
		rank_rd_q <= rank_mem[rank_raddr];
	end

	// memory addressing per state
	always_comb begin
		pair_raddr  = '0;
		pair_waddr  = '0;
		pair_we     = 1'b0;
		pair_wdata  = '0;
		slot_raddr  = '0;
		slot_waddr  = '0;
		slot_we     = 1'b0;
		slot_wdata  = '0;
		pslot_raddr = '0;
		pslot_waddr = '0;
		pslot_we    = 1'b0;
		pslot_wdata = '0;
		rank_raddr  = '0;
		rank_waddr  = '0;
		rank_we     = 1'b0;
		rank_wdata  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				pair_we    = 1'b1;
				pair_waddr = sw_q;
			end
			ST_IDLE: begin
				pair_we    = in_fire && load_ok;
				pair_waddr = pidx(in_data.first_point[PW-1:0], in_data.second_point[PW-1:0]);
				pair_wdata = {1'b1, {(SUM_W-SCORE_W){in_data.score[SCORE_W-1]}}, in_data.score};
			end
			ST_SWEEP_RD: pair_raddr = sw_q;
			ST_SWEEP_WR: begin
				pair_we    = 1'b1;
				pair_waddr = sw_q;
				pair_wdata = {1'b0, (sw_inuse && !pair_rd_q[SUM_W]) ? miss48
					: pair_rd_q[SUM_W-1:0]};
			end
			ST_SLOT_INIT: begin
				slot_we     = 1'b1;
				slot_waddr  = k_q[PW-1:0];
				slot_wdata  = '{active: (k_q < n_q), id: ID_W'(k_q) + 7'd1, size: 7'd1};
				pslot_we    = 1'b1;
				pslot_waddr = k_q[PW-1:0];
				pslot_wdata = k_q[PW-1:0];
			end
			ST_ROW: slot_raddr = a_q[PW-1:0];
			ST_PAIR: begin
				slot_raddr = b_q[PW-1:0];
				pair_raddr = {a_q[PW-1:0], b_q[PW-1:0]};
			end
			ST_MRG_RD1: begin
				slot_raddr = k_q[PW-1:0];
				pair_raddr = pidx(k_q[PW-1:0], keep_q);
			end
			ST_MRG_RD2: pair_raddr = pidx(k_q[PW-1:0], gone_q);
			ST_MRG_WR: begin
				pair_we    = kact_q;
				pair_waddr = pidx(k_q[PW-1:0], keep_q);
				pair_wdata = {1'b0, msat};
			end
			ST_SLOT_GONE: begin
				slot_we    = 1'b1;
				slot_waddr = gone_q;
			end
			ST_SLOT_KEEP: begin
				slot_we    = 1'b1;
				slot_waddr = keep_q;
				slot_wdata = '{active: 1'b1, id: next_id_q + 7'd1, size: bsize_q};
			end
			ST_RL_RD: pslot_raddr = k_q[PW-1:0];
			ST_RL_WR: begin
				pslot_we    = (pslot_rd_q == gone_q);
				pslot_waddr = k_q[PW-1:0];
				pslot_wdata = keep_q;
			end
			ST_RANK_CLR: begin
				rank_we    = 1'b1;
				rank_waddr = r_q;
			end
			ST_MARK_RD: slot_raddr = k_q[PW-1:0];
			ST_MARK_WR: begin
				rank_we    = slot_rd_q.active;
				rank_waddr = slot_rd_q.id;
				rank_wdata = {1'b1, {LABEL_W{1'b0}}};
			end
			ST_RANK_RD: rank_raddr = r_q;
			ST_RANK_WR: begin
				rank_we    = 1'b1;
				rank_waddr = r_q;
				rank_wdata = {rank_rd_q[LABEL_W], rank_next};
			end
			ST_EMIT_RD: pslot_raddr = k_q[PW-1:0];
			ST_EMIT_SLOT, ST_EMIT_RANK, ST_EMIT_OUT: begin
				pslot_raddr = k_q[PW-1:0];
				slot_raddr  = pslot_rd_q;
				rank_raddr  = slot_rd_q.id;
			end
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 31'd65536;
			miss_q   <= 32'h7FFF_FFFF;
			minc_q   <= 7'd1;
			pcount_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				CFG_MISSING:   miss_q   <= cfg_data;
				CFG_MIN_CLUST: minc_q   <= cfg_data[6:0];
				CFG_PCOUNT:    pcount_q <= cfg_data[6:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sw_q        <= '0;
			n_q         <= '0;
			active_q    <= '0;
			next_id_q   <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			r_q         <= '0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			kact_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a label when free, drop valid on transfer
			if (state_q == ST_EMIT_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					sw_q <= sw_q + 1'b1;
					if (sw_q == AW'(PAIRS - 1)) begin
						sw_q    <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire && in_data.kind) begin
						n_q     <= (pcount_q > 7'(MAX_POINTS)) ? CW'(MAX_POINTS)
							: CW'(pcount_q);
						sw_q    <= '0;
						state_q <= ST_SWEEP_RD;
					end
				end
				ST_SWEEP_RD: state_q <= ST_SWEEP_WR;
				ST_SWEEP_WR: begin
					sw_q    <= sw_q + 1'b1;
					state_q <= ST_SWEEP_RD;
					if (sw_q == AW'(PAIRS - 1)) begin
						k_q     <= '0;
						state_q <= ST_SLOT_INIT;
					end
				end
				ST_SLOT_INIT: begin
					k_q <= k_q + 1'b1;
					if (k_q == CW'(MAX_POINTS - 1)) begin
						next_id_q <= ID_W'(n_q);
						active_q  <= n_q;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (7'(active_q) <= minc_q) begin
						r_q     <= '0;
						state_q <= ST_RANK_CLR;
					end else begin
						found_q <= 1'b0;
						a_q     <= '0;
						state_q <= ST_ROW;
					end
				end
				ST_ROW: state_q <= ((a_q + 1'b1) >= n_q) ? ST_MERGE : ST_ROW_D;
				ST_ROW_D: begin
					aslot_q <= slot_rd_q;
					if (!slot_rd_q.active) begin
						a_q     <= a_q + 1'b1;
						state_q <= ST_ROW;
					end else begin
						b_q     <= a_q + 1'b1;
						state_q <= ST_PAIR;
					end
				end
				ST_PAIR: state_q <= ST_PAIR_D;
				ST_PAIR_D: begin
					cand_s1.sum <= pair_rd_q[SUM_W-1:0];
					cand_s1.q   <= {{SIZE_W{1'b0}}, aslot_q.size}
						* {{SIZE_W{1'b0}}, slot_rd_q.size};
					cand_s1.lo  <= (aslot_q.id < slot_rd_q.id) ? aslot_q.id : slot_rd_q.id;
					cand_s1.hi  <= (aslot_q.id < slot_rd_q.id) ? slot_rd_q.id : aslot_q.id;
					ckeep_s1    <= (aslot_q.id < slot_rd_q.id) ? a_q[PW-1:0] : b_q[PW-1:0];
					cgone_s1    <= (aslot_q.id < slot_rd_q.id) ? b_q[PW-1:0] : a_q[PW-1:0];
					csize_s1    <= aslot_q.size + slot_rd_q.size;
					if (slot_rd_q.active) begin
						state_q <= ST_MUL;
					end else if (b_q == n_q - 1'b1) begin
						a_q     <= a_q + 1'b1;
						state_q <= ST_ROW;
					end else begin
						b_q     <= b_q + 1'b1;
						state_q <= ST_PAIR;
					end
				end
				ST_MUL: state_q <= ST_CMP;
				ST_CMP: begin
					if (qualify && (!found_q || better)) begin
						found_q <= 1'b1;
						best_q  <= cand_s1;
						keep_q  <= ckeep_s1;
						gone_q  <= cgone_s1;
						bsize_q <= csize_s1;
					end
					if (b_q == n_q - 1'b1) begin
						a_q     <= a_q + 1'b1;
						state_q <= ST_ROW;
					end else begin
						b_q     <= b_q + 1'b1;
						state_q <= ST_PAIR;
					end
				end
				ST_MERGE: begin
					k_q <= '0;
					r_q <= '0;
					state_q <= found_q ? ST_MRG_RD1 : ST_RANK_CLR;
				end
				ST_MRG_RD1: state_q <= (k_q == n_q) ? ST_SLOT_GONE : ST_MRG_RD2;
				ST_MRG_RD2: begin
					kact_q  <= slot_rd_q.active && (k_q[PW-1:0] != keep_q)
						&& (k_q[PW-1:0] != gone_q);
					sum1_q  <= pair_rd_q[SUM_W-1:0];
					state_q <= ST_MRG_WR;
				end
				ST_MRG_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_MRG_RD1;
				end
				ST_SLOT_GONE: state_q <= ST_SLOT_KEEP;
				ST_SLOT_KEEP: begin
					next_id_q <= next_id_q + 7'd1;
					active_q  <= active_q - 1'b1;
					k_q       <= '0;
					state_q   <= ST_RL_RD;
				end
				ST_RL_RD: state_q <= (k_q == n_q) ? ST_SCAN : ST_RL_WR;
				ST_RL_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_RL_RD;
				end
				ST_RANK_CLR: begin
					r_q <= r_q + 1'b1;
					if (r_q == '1) begin
						k_q     <= '0;
						state_q <= ST_MARK_RD;
					end
				end
				ST_MARK_RD: begin
					if (k_q == n_q) begin
						cnt_q   <= '0;
						state_q <= ST_RANK_RD;
					end else begin
						state_q <= ST_MARK_WR;
					end
				end
				ST_MARK_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_MARK_RD;
				end
				ST_RANK_RD: state_q <= ST_RANK_WR;
				ST_RANK_WR: begin
					cnt_q   <= rank_next;
					r_q     <= r_q + 1'b1;
					state_q <= ST_RANK_RD;
					if (r_q == '1) begin
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD:   state_q <= (k_q == n_q) ? ST_IDLE : ST_EMIT_SLOT;
				ST_EMIT_SLOT: state_q <= ST_EMIT_RANK;
				ST_EMIT_RANK: state_q <= ST_EMIT_OUT;
				ST_EMIT_OUT: begin
					if (out_free) begin
						out_q.point_index   <= POINT_W'(k_q[PW-1:0]);
						out_q.cluster_label <= rank_rd_q[LABEL_W-1:0];
						out_q.last          <= (k_q == n_q - 1'b1);
						k_q                 <= k_q + 1'b1;
						state_q             <= ST_EMIT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cluster count never exceeds the points in use once merging is under way
	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (active_q <= n_q))
		else $error("active cluster count above point count");

	// a merge always joins two distinct slots picked by the scan
	a_merge_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLOT_KEEP) |-> (found_q && (keep_q != gone_q)))
		else $error("merge without a valid distinct pair");

	// every emitted label is a nonzero rank
	a_label_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.cluster_label != '0))
		else $error("zero cluster label emitted");

	// merging only starts while the count is still above the floor
	a_merge_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW && $past(state_q) == ST_SCAN) |-> (7'(active_q) > minc_q))
		else $error("scan started at or below minimum cluster count");

endmodule
